@@ rtl/prt_pkg.sv @@
// shared types, constants and the cordic arctangent table of the planar rigid transform unit
package prt_pkg;

    // word formats
    localparam int ANGLE_BITS   = 16;
    localparam int COORD_BITS   = 32;
    localparam int CORDIC_STEPS = 16;

    // cordic datapath, q2.30
    localparam int TRIG_W  = 32;
    localparam int CNT_W   = $clog2(CORDIC_STEPS);
    localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 32'sh26DD3B6A;

    // operation classes
    typedef enum logic [2:0] {
        OP_LOAD    = 3'd0,
        OP_APPLY   = 3'd1,
        OP_COMPOSE = 3'd2,
        OP_INVERT  = 3'd3,
        OP_TWIST   = 3'd4,
        OP_NOP     = 3'd5
    } t_op;

    // one classified input word
    typedef struct packed {
        t_op                     op;
        logic [ANGLE_BITS-1:0]   angle;
        logic [COORD_BITS-1:0]   rate;
        logic [COORD_BITS-1:0]   x;
        logic [COORD_BITS-1:0]   y;
    } t_item;

    // cordic result towards the back end
    typedef struct packed {
        logic                done;
        logic [TRIG_W-1:0]   cos_v;
        logic [TRIG_W-1:0]   sin_v;
    } t_trig;

    // multiplier operand selects
    typedef enum logic [1:0] {
        A_COS = 2'd0,
        A_SIN = 2'd1,
        A_PX  = 2'd2,
        A_PY  = 2'd3
    } t_asel;

    typedef enum logic [2:0] {
        B_X    = 3'd0,
        B_Y    = 3'd1,
        B_RATE = 3'd2,
        B_PX   = 3'd3,
        B_PY   = 3'd4
    } t_bsel;

    // one product term of an operation
    typedef struct packed {
        logic  act;
        logic  last;
        t_asel asel;
        t_bsel bsel;
        logic  rate_sh;
        logic  neg;
        logic  to_y;
    } t_term;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_TRIG  = 3'd1,
        S_MAC   = 3'd2,
        S_DRAIN = 3'd3,
        S_DONE  = 3'd4
    } t_back_state;

    // back end status
    typedef struct packed {
        logic take;
        logic busy;
    } t_back_stat;

    // arctangent of 2^-i in q30 turns of a quarter
    function automatic logic [TRIG_W-1:0] atan_q30(input logic [4:0] i);
        logic [TRIG_W-1:0] r;
        unique case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/prt_front.sv @@
// front end: accepts input words, classifies the operation and queues them for the back end
module prt_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [2:0]                          i_operation,
    input  logic [prt_pkg::ANGLE_BITS-1:0]      i_in_angle,
    input  logic [prt_pkg::COORD_BITS-1:0]      i_in_rate,
    input  logic [prt_pkg::COORD_BITS-1:0]      i_in_x,
    input  logic [prt_pkg::COORD_BITS-1:0]      i_in_y,
    output logic                                o_valid,
    output prt_pkg::t_item                      o_item,
    input  logic                                i_take
);

    prt_pkg::t_item r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    prt_pkg::t_item w_in;
    logic           w_wr;

    // classify: codes past twist do nothing
    always_comb begin
        w_in.op    = (i_operation > 3'd4) ? prt_pkg::OP_NOP : prt_pkg::t_op'(i_operation);
        w_in.angle = i_in_angle;
        w_in.rate  = i_in_rate;
        w_in.x     = i_in_x;
        w_in.y     = i_in_y;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_wr    = i_push && !o_full;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_in;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, i_take};
        end
    end

endmodule

@@ rtl/prt_cordic.sv @@
// iterative rotation-mode cordic, one micro-rotation a cycle, with quadrant folding
module prt_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [prt_pkg::ANGLE_BITS-1:0]    i_angle,
    output prt_pkg::t_trig                    o_trig
);

    localparam int TW = prt_pkg::TRIG_W;

    logic signed [TW-1:0]          r_x;
    logic signed [TW-1:0]          r_y;
    logic signed [TW-1:0]          r_z;
    logic [1:0]                    r_q;
    logic [prt_pkg::CNT_W-1:0]     r_i;
    logic                          r_busy;
    logic                          r_done;
    logic [31:0]                   w_phase;
    logic signed [TW-1:0]          w_at;

    assign w_phase = {i_angle, {(32 - prt_pkg::ANGLE_BITS){1'b0}}};
    assign w_at    = $signed(prt_pkg::atan_q30(5'(r_i)));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (r_i == prt_pkg::CNT_W'(prt_pkg::CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // micro-rotations
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= prt_pkg::GAIN_Q30;
            r_y <= '0;
            r_z <= $signed({2'b00, w_phase[29:0]});
            r_q <= w_phase[31:30];
        end else if (r_busy) begin
            if (!r_z[TW-1]) begin
                r_x <= r_x - (r_y >>> r_i);
                r_y <= r_y + (r_x >>> r_i);
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + (r_y >>> r_i);
                r_y <= r_y - (r_x >>> r_i);
                r_z <= r_z + w_at;
            end
        end
    end

    // quadrant unfolding
    always_comb begin
        o_trig.done = r_done;
        unique case (r_q)
            2'd0: begin
                o_trig.cos_v = r_x;
                o_trig.sin_v = r_y;
            end
            2'd1: begin
                o_trig.cos_v = -r_y;
                o_trig.sin_v = r_x;
            end
            2'd2: begin
                o_trig.cos_v = -r_x;
                o_trig.sin_v = -r_y;
            end
            default: begin
                o_trig.cos_v = r_y;
                o_trig.sin_v = -r_x;
            end
        endcase
    end

endmodule

@@ rtl/prt_back.sv @@
// back end: holds the pose, sequences the product terms through one multiplier, drives the result word
module prt_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  prt_pkg::t_item                    i_item,
    output logic                              o_take,
    output prt_pkg::t_back_stat               o_stat,
    output logic                              o_trig_start,
    output logic [prt_pkg::ANGLE_BITS-1:0]    o_trig_angle,
    input  prt_pkg::t_trig                    i_trig,
    input  logic                              i_pop,
    output logic                              o_empty,
    output logic [prt_pkg::ANGLE_BITS-1:0]    o_out_angle,
    output logic [prt_pkg::COORD_BITS-1:0]    o_out_rate,
    output logic [prt_pkg::COORD_BITS-1:0]    o_out_x,
    output logic [prt_pkg::COORD_BITS-1:0]    o_out_y,
    output logic                              o_saturated
);

    localparam int CB    = prt_pkg::COORD_BITS;
    localparam int AB    = prt_pkg::ANGLE_BITS;
    localparam int AW    = (CB > prt_pkg::TRIG_W) ? CB : prt_pkg::TRIG_W;
    localparam int PW    = AW + CB;
    localparam int EW    = (PW + 1 > 64) ? PW + 1 : 64;
    localparam int ACC_W = 66;

    localparam logic signed [EW-1:0] LIM_P = {{(EW-62){1'b0}}, 1'b1, 61'b0};
    localparam logic signed [EW-1:0] LIM_N = {{(EW-61){1'b1}}, 61'b0};
    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-CB+1){1'b1}}, {(CB-1){1'b0}}};
    localparam logic signed [PW:0] HALF_T = {{(PW+1-30){1'b0}}, 1'b1, 29'b0};
    localparam logic signed [PW:0] HALF_R = {{(PW+1-16){1'b0}}, 1'b1, 15'b0};

    prt_pkg::t_back_state r_state;
    prt_pkg::t_back_state n_state;
    prt_pkg::t_item       r_item;
    logic [AB-1:0]        r_pose_angle;
    logic signed [CB-1:0] r_pose_x;
    logic signed [CB-1:0] r_pose_y;
    logic [2:0]           r_step;
    logic                 r_pv;
    prt_pkg::t_term       r_meta;
    logic signed [PW-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc_x;
    logic signed [ACC_W-1:0] r_acc_y;
    logic                 r_out_valid;
    logic [AB-1:0]        r_out_angle;
    logic [CB-1:0]        r_out_rate;
    logic [CB-1:0]        r_out_x;
    logic [CB-1:0]        r_out_y;
    logic                 r_out_sat;

    logic                 w_issue;
    logic                 w_write;
    logic                 w_out_free;
    prt_pkg::t_term       w_term;
    logic signed [AW-1:0] w_a;
    logic signed [CB-1:0] w_b;
    logic signed [PW:0]   w_rnd;
    logic signed [EW-1:0] w_ext;
    logic signed [EW-1:0] w_clip;
    logic signed [ACC_W-1:0] w_add;
    logic signed [CB-1:0] w_sx;
    logic signed [CB-1:0] w_sy;
    logic                 w_fx;
    logic                 w_fy;

    assign w_out_free = !r_out_valid || i_pop;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prt_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = prt_pkg::S_TRIG;
                end
            end
            prt_pkg::S_TRIG: begin
                if (i_trig.done) begin
                    if (r_item.op == prt_pkg::OP_LOAD || r_item.op == prt_pkg::OP_NOP) begin
                        n_state = prt_pkg::S_DONE;
                    end else begin
                        n_state = prt_pkg::S_MAC;
                    end
                end
            end
            prt_pkg::S_MAC: begin
                if (w_term.last) begin
                    n_state = prt_pkg::S_DRAIN;
                end
            end
            prt_pkg::S_DRAIN: begin
                n_state = prt_pkg::S_DONE;
            end
            prt_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = prt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = prt_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_take       = (r_state == prt_pkg::S_IDLE) && i_valid;
        o_trig_start = o_take;
        w_issue      = (r_state == prt_pkg::S_MAC);
        w_write      = (r_state == prt_pkg::S_DONE) && w_out_free;
        o_stat.take  = o_take;
        o_stat.busy  = (r_state != prt_pkg::S_IDLE);
    end

    assign o_trig_angle = r_pose_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // term table per operation
    always_comb begin
        w_term = '{act: 1'b0, last: 1'b1, asel: prt_pkg::A_COS, bsel: prt_pkg::B_X,
                   rate_sh: 1'b0, neg: 1'b0, to_y: 1'b0};
        unique case (r_item.op)
            prt_pkg::OP_APPLY, prt_pkg::OP_COMPOSE: begin
                w_term.act  = 1'b1;
                w_term.last = (r_step == 3'd3);
                unique case (r_step)
                    3'd0: begin
                        w_term.asel = prt_pkg::A_COS; w_term.bsel = prt_pkg::B_X;
                    end
                    3'd1: begin
                        w_term.asel = prt_pkg::A_SIN; w_term.bsel = prt_pkg::B_Y;
                        w_term.neg  = 1'b1;
                    end
                    3'd2: begin
                        w_term.asel = prt_pkg::A_SIN; w_term.bsel = prt_pkg::B_X;
                        w_term.to_y = 1'b1;
                    end
                    default: begin
                        w_term.asel = prt_pkg::A_COS; w_term.bsel = prt_pkg::B_Y;
                        w_term.to_y = 1'b1;
                    end
                endcase
            end
            prt_pkg::OP_INVERT: begin
                w_term.act  = 1'b1;
                w_term.last = (r_step == 3'd3);
                unique case (r_step)
                    3'd0: begin
                        w_term.asel = prt_pkg::A_COS; w_term.bsel = prt_pkg::B_PX;
                        w_term.neg  = 1'b1;
                    end
                    3'd1: begin
                        w_term.asel = prt_pkg::A_SIN; w_term.bsel = prt_pkg::B_PY;
                        w_term.neg  = 1'b1;
                    end
                    3'd2: begin
                        w_term.asel = prt_pkg::A_SIN; w_term.bsel = prt_pkg::B_PX;
                        w_term.to_y = 1'b1;
                    end
                    default: begin
                        w_term.asel = prt_pkg::A_COS; w_term.bsel = prt_pkg::B_PY;
                        w_term.neg  = 1'b1; w_term.to_y = 1'b1;
                    end
                endcase
            end
            prt_pkg::OP_TWIST: begin
                w_term.act  = 1'b1;
                w_term.last = (r_step == 3'd5);
                unique case (r_step)
                    3'd0: begin
                        w_term.asel = prt_pkg::A_PY; w_term.bsel = prt_pkg::B_RATE;
                        w_term.rate_sh = 1'b1;
                    end
                    3'd1: begin
                        w_term.asel = prt_pkg::A_COS; w_term.bsel = prt_pkg::B_X;
                    end
                    3'd2: begin
                        w_term.asel = prt_pkg::A_SIN; w_term.bsel = prt_pkg::B_Y;
                        w_term.neg  = 1'b1;
                    end
                    3'd3: begin
                        w_term.asel = prt_pkg::A_PX; w_term.bsel = prt_pkg::B_RATE;
                        w_term.rate_sh = 1'b1; w_term.neg = 1'b1; w_term.to_y = 1'b1;
                    end
                    3'd4: begin
                        w_term.asel = prt_pkg::A_SIN; w_term.bsel = prt_pkg::B_X;
                        w_term.to_y = 1'b1;
                    end
                    default: begin
                        w_term.asel = prt_pkg::A_COS; w_term.bsel = prt_pkg::B_Y;
                        w_term.to_y = 1'b1;
                    end
                endcase
            end
            default: begin
                w_term.act = 1'b0;
            end
        endcase
    end

    // operand selection
    always_comb begin
        unique case (w_term.asel)
            prt_pkg::A_COS: w_a = AW'($signed(i_trig.cos_v));
            prt_pkg::A_SIN: w_a = AW'($signed(i_trig.sin_v));
            prt_pkg::A_PX:  w_a = AW'(r_pose_x);
            default:        w_a = AW'(r_pose_y);
        endcase
        unique case (w_term.bsel)
            prt_pkg::B_X:    w_b = $signed(r_item.x);
            prt_pkg::B_Y:    w_b = $signed(r_item.y);
            prt_pkg::B_RATE: w_b = $signed(r_item.rate);
            prt_pkg::B_PX:   w_b = r_pose_x;
            prt_pkg::B_PY:   w_b = r_pose_y;
            default:         w_b = '0;
        endcase
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= w_issue && w_term.act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_prod <= w_a * w_b;
            r_meta <= w_term;
        end
    end

    // round half up, clip and align the registered product
    always_comb begin
        if (r_meta.rate_sh) begin
            w_rnd = ($signed({r_prod[PW-1], r_prod}) + HALF_R) >>> 16;
        end else begin
            w_rnd = ($signed({r_prod[PW-1], r_prod}) + HALF_T) >>> 30;
        end
        w_ext = EW'(w_rnd);
        if (w_ext > LIM_P) begin
            w_clip = LIM_P;
        end else if (w_ext < LIM_N) begin
            w_clip = LIM_N;
        end else begin
            w_clip = w_ext;
        end
        w_add = ACC_W'($signed(w_clip[62:0]));
    end

    // step counter and accumulators
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_item <= i_item;
            r_step <= 3'd0;
            if (i_item.op == prt_pkg::OP_APPLY || i_item.op == prt_pkg::OP_COMPOSE) begin
                r_acc_x <= ACC_W'(r_pose_x);
                r_acc_y <= ACC_W'(r_pose_y);
            end else begin
                r_acc_x <= '0;
                r_acc_y <= '0;
            end
        end else begin
            if (w_issue) begin
                r_step <= r_step + 3'd1;
            end
            if (r_pv) begin
                if (r_meta.to_y) begin
                    r_acc_y <= r_meta.neg ? r_acc_y - w_add : r_acc_y + w_add;
                end else begin
                    r_acc_x <= r_meta.neg ? r_acc_x - w_add : r_acc_x + w_add;
                end
            end
        end
    end

    // saturate to the coordinate range
    always_comb begin
        w_fx = 1'b0;
        w_fy = 1'b0;
        if (r_acc_x > SAT_HI) begin
            w_sx = SAT_HI[CB-1:0]; w_fx = 1'b1;
        end else if (r_acc_x < SAT_LO) begin
            w_sx = SAT_LO[CB-1:0]; w_fx = 1'b1;
        end else begin
            w_sx = r_acc_x[CB-1:0];
        end
        if (r_acc_y > SAT_HI) begin
            w_sy = SAT_HI[CB-1:0]; w_fy = 1'b1;
        end else if (r_acc_y < SAT_LO) begin
            w_sy = SAT_LO[CB-1:0]; w_fy = 1'b1;
        end else begin
            w_sy = r_acc_y[CB-1:0];
        end
    end

    // pose update and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_angle <= '0;
            r_pose_x     <= '0;
            r_pose_y     <= '0;
        end else if (w_write) begin
            unique case (r_item.op)
                prt_pkg::OP_LOAD: begin
                    r_pose_angle <= r_item.angle;
                    r_pose_x     <= $signed(r_item.x);
                    r_pose_y     <= $signed(r_item.y);
                end
                prt_pkg::OP_COMPOSE: begin
                    r_pose_angle <= r_pose_angle + r_item.angle;
                    r_pose_x     <= w_sx;
                    r_pose_y     <= w_sy;
                end
                prt_pkg::OP_INVERT: begin
                    r_pose_angle <= -r_pose_angle;
                    r_pose_x     <= w_sx;
                    r_pose_y     <= w_sy;
                end
                default: begin
                    r_pose_angle <= r_pose_angle;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_out_rate <= '0;
            r_out_sat  <= 1'b0;
            unique case (r_item.op)
                prt_pkg::OP_LOAD: begin
                    r_out_angle <= r_item.angle;
                    r_out_x     <= r_item.x;
                    r_out_y     <= r_item.y;
                end
                prt_pkg::OP_APPLY: begin
                    r_out_angle <= r_pose_angle;
                    r_out_x     <= w_sx;
                    r_out_y     <= w_sy;
                    r_out_sat   <= w_fx | w_fy;
                end
                prt_pkg::OP_COMPOSE: begin
                    r_out_angle <= r_pose_angle + r_item.angle;
                    r_out_x     <= w_sx;
                    r_out_y     <= w_sy;
                    r_out_sat   <= w_fx | w_fy;
                end
                prt_pkg::OP_INVERT: begin
                    r_out_angle <= -r_pose_angle;
                    r_out_x     <= w_sx;
                    r_out_y     <= w_sy;
                    r_out_sat   <= w_fx | w_fy;
                end
                prt_pkg::OP_TWIST: begin
                    r_out_angle <= r_pose_angle;
                    r_out_rate  <= r_item.rate;
                    r_out_x     <= w_sx;
                    r_out_y     <= w_sy;
                    r_out_sat   <= w_fx | w_fy;
                end
                default: begin
                    r_out_angle <= r_pose_angle;
                    r_out_x     <= r_pose_x;
                    r_out_y     <= r_pose_y;
                end
            endcase
        end
    end

    // output slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_write) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_out_angle = r_out_angle;
    assign o_out_rate  = r_out_rate;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_saturated = r_out_sat;

endmodule

@@ rtl/planar_rigid_transform_unit_top.sv @@
// one word is in the back end at a time: a new word is taken only after the result of the last
// one is written, and the pace is set by the iterative cordic and the shared multiplier.
// a two-word input queue and a one-word result register decouple the two sides.
// reset is synchronous, active low: queues empty and the pose returns to identity.
module planar_rigid_transform_unit_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [2:0]                        i_operation,
    input  logic [prt_pkg::ANGLE_BITS-1:0]    i_in_angle,
    input  logic [prt_pkg::COORD_BITS-1:0]    i_in_rate,
    input  logic [prt_pkg::COORD_BITS-1:0]    i_in_x,
    input  logic [prt_pkg::COORD_BITS-1:0]    i_in_y,
    output logic                              empty,
    input  logic                              pop,
    output logic [prt_pkg::ANGLE_BITS-1:0]    o_out_angle,
    output logic [prt_pkg::COORD_BITS-1:0]    o_out_rate,
    output logic [prt_pkg::COORD_BITS-1:0]    o_out_x,
    output logic [prt_pkg::COORD_BITS-1:0]    o_out_y,
    output logic                              o_saturated
);

    logic                            w_fq_valid;
    prt_pkg::t_item                  w_fq_item;
    logic                            w_take;
    prt_pkg::t_back_stat             w_stat;
    logic                            w_trig_start;
    logic [prt_pkg::ANGLE_BITS-1:0]  w_trig_angle;
    prt_pkg::t_trig                  w_trig;

    // input queue and classification
    prt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_operation (i_operation),
        .i_in_angle  (i_in_angle),
        .i_in_rate   (i_in_rate),
        .i_in_x      (i_in_x),
        .i_in_y      (i_in_y),
        .o_valid     (w_fq_valid),
        .o_item      (w_fq_item),
        .i_take      (w_take)
    );

    // sine and cosine of the pose angle
    prt_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_trig_start),
        .i_angle (w_trig_angle),
        .o_trig  (w_trig)
    );

    // pose, arithmetic and result word
    prt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_fq_valid),
        .i_item       (w_fq_item),
        .o_take       (w_take),
        .o_stat       (w_stat),
        .o_trig_start (w_trig_start),
        .o_trig_angle (w_trig_angle),
        .i_trig       (w_trig),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_angle  (o_out_angle),
        .o_out_rate   (o_out_rate),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_saturated  (o_saturated)
    );

`ifndef SYNTHESIS
    // the back end only takes a word that the queue holds
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.take |-> w_fq_valid) else $error("take from empty queue");

    // a taken word keeps the back end busy
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.take |=> w_stat.busy) else $error("back end idle after take");

    // a taken word leaves the back end idle first
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.take |-> !w_stat.busy) else $error("take while busy");
`endif

endmodule

@@ tb/tb.sv @@
// self-checking testbench of the planar rigid transform unit
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int LONG_HOLD      = 300;

    typedef struct {
        logic [2:0]         op;
        logic [15:0]        angle;
        logic signed [31:0] rate;
        logic signed [31:0] x;
        logic signed [31:0] y;
        bit                 drain_first;
    } t_word_in;

    typedef struct {
        logic [15:0] angle;
        logic [31:0] rate;
        logic [31:0] x;
        logic [31:0] y;
        logic        sat;
    } t_word_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_operation = '0;
    logic [15:0] i_in_angle = '0;
    logic [31:0] i_in_rate = '0;
    logic [31:0] i_in_x = '0;
    logic [31:0] i_in_y = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] o_out_angle;
    logic [31:0] o_out_rate;
    logic [31:0] o_out_x;
    logic [31:0] o_out_y;
    logic        o_saturated;

    planar_rigid_transform_unit_top dut (.*);

    // clock
    always #6 i_clk = ~i_clk;

    // pose copy held by the predictor
    logic [15:0] pose_ang = '0;
    longint      pose_px = 0;
    longint      pose_py = 0;

    t_word_in  pending_words[$];
    t_word_out expected_words[$];
    int        errors = 0;
    int        words_sent = 0;
    int        words_checked = 0;
    int        op_seen[8];
    int        sat_seen = 0;
    int        idle_cycles = 0;
    bit        stim_done = 0;

    // cordic cosine and sine in q2.30
    function automatic void cordic_trig(input logic [15:0] a, output longint c,
                                        output longint s);
        logic [31:0] phase;
        longint      cx, cy, z, nx;
        phase = {a, 16'h0};
        cx = prt_pkg::GAIN_Q30;
        cy = 0;
        z  = phase[29:0];
        for (int i = 0; i < prt_pkg::CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                z  = z - longint'(prt_pkg::atan_q30(5'(i)));
            end else begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                z  = z + longint'(prt_pkg::atan_q30(5'(i)));
            end
            cx = nx;
        end
        case (phase[31:30])
            2'd0: begin c = cx;  s = cy;  end
            2'd1: begin c = -cy; s = cx;  end
            2'd2: begin c = -cx; s = -cy; end
            default: begin c = cy; s = -cx; end
        endcase
    endfunction

    // exact product, rounded half up, clipped to +-2^61
    function automatic longint mul_rnd(input longint a, input longint b, input int sh);
        logic signed [127:0] pa, pb, p;
        pa = a;
        pb = b;
        p = pa * pb + (128'sd1 <<< (sh - 1));
        p = p >>> sh;
        if (p > (128'sd1 <<< 61)) p = 128'sd1 <<< 61;
        if (p < -(128'sd1 <<< 61)) p = -(128'sd1 <<< 61);
        return p[63:0];
    endfunction

    function automatic longint clip32(input longint v, inout logic flag);
        if (v > 64'sd2147483647) begin flag = 1'b1; return 64'sd2147483647; end
        if (v < -64'sd2147483648) begin flag = 1'b1; return -64'sd2147483648; end
        return v;
    endfunction

    // next pose and result word for one accepted input word
    function automatic t_word_out transform_word(input t_word_in w);
        t_word_out r;
        longint    c, s, rx, ry, ix, iy, rt, orate;
        logic      flag;
        flag = 1'b0;
        orate = 0;
        ix = w.x;
        iy = w.y;
        rt = w.rate;
        cordic_trig(pose_ang, c, s);
        case (w.op)
            prt_pkg::OP_LOAD: begin
                pose_ang = w.angle; pose_px = ix; pose_py = iy;
                rx = ix; ry = iy;
            end
            prt_pkg::OP_APPLY: begin
                rx = clip32(mul_rnd(c, ix, 30) - mul_rnd(s, iy, 30) + pose_px, flag);
                ry = clip32(mul_rnd(s, ix, 30) + mul_rnd(c, iy, 30) + pose_py, flag);
            end
            prt_pkg::OP_COMPOSE: begin
                rx = clip32(pose_px + mul_rnd(c, ix, 30) - mul_rnd(s, iy, 30), flag);
                ry = clip32(pose_py + mul_rnd(s, ix, 30) + mul_rnd(c, iy, 30), flag);
                pose_px = rx; pose_py = ry;
                pose_ang = pose_ang + w.angle;
            end
            prt_pkg::OP_INVERT: begin
                rx = clip32(-(mul_rnd(c, pose_px, 30) + mul_rnd(s, pose_py, 30)), flag);
                ry = clip32(mul_rnd(s, pose_px, 30) - mul_rnd(c, pose_py, 30), flag);
                pose_px = rx; pose_py = ry;
                pose_ang = -pose_ang;
            end
            prt_pkg::OP_TWIST: begin
                orate = rt;
                rx = clip32(mul_rnd(pose_py, rt, 16) + mul_rnd(c, ix, 30)
                            - mul_rnd(s, iy, 30), flag);
                ry = clip32(-mul_rnd(pose_px, rt, 16) + mul_rnd(s, ix, 30)
                            + mul_rnd(c, iy, 30), flag);
            end
            default: begin
                rx = pose_px; ry = pose_py;
            end
        endcase
        r.angle = pose_ang;
        r.rate  = orate[31:0];
        r.x     = rx[31:0];
        r.y     = ry[31:0];
        r.sat   = flag;
        return r;
    endfunction

    // coordinate mix: mostly moderate, some full range, some extremes
    function automatic logic [31:0] coord_val();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
        if (pick < 8) return $urandom();
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic t_word_in make_word(input logic [2:0] op, input logic [15:0] a,
                                           input logic [31:0] rt, input logic [31:0] x,
                                           input logic [31:0] y);
        t_word_in w;
        w.op = op; w.angle = a; w.rate = rt; w.x = x; w.y = y; w.drain_first = 0;
        return w;
    endfunction

    // driver: presents queued words with random gaps
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_word_in  w;
        logic      next_push;
        bit        accepted;
        next_push = push;
        accepted = push && !full;
        if (!i_rst_n) begin
            next_push = 1'b0;
        end else begin
            if (accepted) begin
                w = pending_words.pop_front();
                expected_words.push_back(transform_word(w));
                op_seen[w.op]++;
                words_sent++;
                case ($urandom_range(0, 19))
                    0:          gap_left = $urandom_range(20, 60);
                    1, 2, 3, 4, 5, 6: gap_left = $urandom_range(1, 3);
                    default:    gap_left = 0;
                endcase
                next_push = 1'b0;
            end
            if (!push || accepted) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() > 0 && (!pending_words[0].drain_first
                             || (expected_words.size() == 0 && !accepted))) begin
                    next_push = 1'b1;
                    i_operation <= pending_words[0].op;
                    i_in_angle  <= pending_words[0].angle;
                    i_in_rate   <= pending_words[0].rate;
                    i_in_x      <= pending_words[0].x;
                    i_in_y      <= pending_words[0].y;
                end
            end
        end
        push <= next_push;
    end

    // monitor: random pop with one long hold-off, checks against the oldest expectation
    int hold_left = 0;
    bit long_hold_done = 0;
    always @(posedge i_clk) begin
        t_word_out e;
        logic      next_pop;
        next_pop = 1'b0;
        if (i_rst_n) begin
            if (pop && !empty) begin
                words_checked++;
                if (o_saturated) sat_seen++;
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    e = expected_words.pop_front();
                    if (o_out_angle !== e.angle) begin
                        $error("out_angle exp %h got %h", e.angle, o_out_angle); errors++;
                    end
                    if (o_out_rate !== e.rate) begin
                        $error("out_rate exp %h got %h", e.rate, o_out_rate); errors++;
                    end
                    if (o_out_x !== e.x) begin
                        $error("out_x exp %h got %h", e.x, o_out_x); errors++;
                    end
                    if (o_out_y !== e.y) begin
                        $error("out_y exp %h got %h", e.y, o_out_y); errors++;
                    end
                    if (o_saturated !== e.sat) begin
                        $error("saturated exp %b got %b", e.sat, o_saturated); errors++;
                    end
                end
            end
            if (!long_hold_done && words_checked == 120) begin
                long_hold_done = 1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else begin
                case ($urandom_range(0, 19))
                    0:       hold_left = $urandom_range(20, 60);
                    1, 2, 3, 4, 5: hold_left = $urandom_range(1, 3);
                    default: next_pop = 1'b1;
                endcase
            end
        end
        pop <= next_pop;
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n)
            idle_cycles = 0;
        else if (++idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        logic [15:0] angs[5];
        t_word_in    w;
        int          op;
        angs = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
        // directed: identity apply, quadrant angles, extremes, unused codes
        pending_words.push_back(make_word(prt_pkg::OP_APPLY, 0, 0, 32'h0001_0000,
                                          32'hFFFF_0000));
        foreach (angs[k]) begin
            pending_words.push_back(make_word(prt_pkg::OP_LOAD, angs[k], 0, 32'h0003_0000,
                                              32'hFFFE_8000));
            pending_words.push_back(make_word(prt_pkg::OP_APPLY, 0, 0, 32'h0001_0000,
                                              32'h0002_0000));
        end
        pending_words.push_back(make_word(prt_pkg::OP_LOAD, 16'h2000, 0, 32'h7FFF_FFFF,
                                          32'h8000_0000));
        pending_words.push_back(make_word(prt_pkg::OP_APPLY, 0, 0, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF));
        pending_words.push_back(make_word(prt_pkg::OP_TWIST, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                                          32'h7FFF_FFFF));
        pending_words.push_back(make_word(prt_pkg::OP_TWIST, 0, 32'h8000_0000, 0, 0));
        pending_words.push_back(make_word(prt_pkg::OP_COMPOSE, 16'hFFFF, 0, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF));
        pending_words.push_back(make_word(prt_pkg::OP_INVERT, 16'hFFFF, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_words.push_back(make_word(prt_pkg::OP_INVERT, 0, 0, 0, 0));
        for (int k = 5; k < 8; k++)
            pending_words.push_back(make_word(3'(k), 16'hFFFF, 32'hFFFF_FFFF, 32'h1234_5678,
                                              32'h8765_4321));
        pending_words.push_back(make_word(prt_pkg::OP_LOAD, 0, 0, 0, 0));
        // random: pose setups followed by work, with occasional pauses to drain
        for (int k = 0; k < 680; k++) begin
            op = $urandom_range(0, 19);
            if (op < 2) op = prt_pkg::OP_LOAD;
            else if (op < 7) op = prt_pkg::OP_APPLY;
            else if (op < 11) op = prt_pkg::OP_COMPOSE;
            else if (op < 14) op = prt_pkg::OP_INVERT;
            else if (op < 19) op = prt_pkg::OP_TWIST;
            else op = $urandom_range(5, 7);
            w = make_word(3'(op), 16'($urandom()), coord_val(), coord_val(), coord_val());
            w.drain_first = (k % 170 == 60);
            pending_words.push_back(w);
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_words.size() == 0);
        wait (expected_words.size() == 0);
        repeat (40) @(posedge i_clk);
        $display("%0d words sent, %0d results checked, %0d saturated", words_sent,
                 words_checked, sat_seen);
        $display("ops load %0d apply %0d compose %0d invert %0d twist %0d unused %0d",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
                 op_seen[5] + op_seen[6] + op_seen[7]);
        if (errors == 0 && expected_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
